### sv/msqe_pkg.sv
package msqe_pkg;

  localparam int NUM_LISTS   = 16;
  localparam int POOL_DEPTH  = 1024;
  localparam int VALUE_WIDTH = 32;

  localparam int PTR_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int LIST_IDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_PUSH   = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXISTS  = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         list_id;
    logic               kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] popped_value;
    logic               value_valid;
  } res_t;

  // Port requests toward the node value and node link memories.
  typedef struct packed {
    logic                   val_we;
    logic                   link_we;
    logic [PTR_W-1:0]       waddr;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic [PTR_W-1:0]       link_wdata;
    logic [PTR_W-1:0]       raddr;
  } mem_req_t;

endpackage

### sv/msqe_ram.sv
module msqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/msqe_seq.sv
module msqe_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  msqe_pkg::cmd_t                   cmd_in,
  input  logic [msqe_pkg::VALUE_WIDTH-1:0] val_rdata,
  input  logic [msqe_pkg::PTR_W-1:0]       link_rdata,
  output msqe_pkg::mem_req_t               mem_req,
  output logic                             busy,
  output logic                             done,
  output msqe_pkg::res_t                   res
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_PUSH_WAIT = 3'd2;
  localparam logic [2:0] S_PUSH_WR   = 3'd3;
  localparam logic [2:0] S_PUSH_LINK = 3'd4;
  localparam logic [2:0] S_POP_WAIT  = 3'd5;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  msqe_pkg::cmd_t                   cmd;
  logic [msqe_pkg::PTR_W-1:0]       node;
  logic [msqe_pkg::CNT_W-1:0]       fresh_ptr;
  logic [msqe_pkg::PTR_W-1:0]       free_head;
  logic [msqe_pkg::CNT_W-1:0]       free_count;

  logic                             list_exists   [msqe_pkg::NUM_LISTS];
  logic                             list_is_queue [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::PTR_W-1:0]       head_ptr      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::PTR_W-1:0]       tail_ptr      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::CNT_W-1:0]       entry_count   [msqe_pkg::NUM_LISTS];

  logic [msqe_pkg::LIST_IDX_W-1:0]  id;
  logic                             id_ok;
  logic                             cnt_zero;

  assign id       = cmd.list_id[msqe_pkg::LIST_IDX_W-1:0];
  assign id_ok    = int'(cmd.list_id) < msqe_pkg::NUM_LISTS;
  assign cnt_zero = (entry_count[id] == '0);
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next          = state;
    done                = 1'b0;
    res                 = '0;
    mem_req             = '0;
    mem_req.waddr       = node;
    mem_req.val_wdata   = cmd.value[msqe_pkg::VALUE_WIDTH-1:0];
    // Push reads the link of the free-list head; pop reads the list head.
    mem_req.raddr       = (cmd.mode == msqe_pkg::MODE_POP) ? head_ptr[id] : free_head;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        done       = 1'b1;
        state_next = S_IDLE;
        res.status = msqe_pkg::ST_OK;
        if (cmd.mode == msqe_pkg::MODE_NONE) begin
          res.status = msqe_pkg::ST_OK;
        end else if (!id_ok) begin
          res.status = msqe_pkg::ST_MISSING;
        end else if (cmd.mode == msqe_pkg::MODE_CREATE) begin
          if (list_exists[id]) begin
            res.status = msqe_pkg::ST_EXISTS;
          end
        end else if (!list_exists[id]) begin
          res.status = msqe_pkg::ST_MISSING;
        end else if (cmd.mode == msqe_pkg::MODE_PUSH) begin
          if (free_count != '0) begin
            done       = 1'b0;
            state_next = S_PUSH_WAIT;
          end else if (fresh_ptr != msqe_pkg::CNT_W'(msqe_pkg::POOL_DEPTH)) begin
            done       = 1'b0;
            state_next = S_PUSH_WR;
          end else begin
            res.status = msqe_pkg::ST_FULL;
          end
        end else begin
          if (cnt_zero) begin
            res.status = msqe_pkg::ST_EMPTY;
          end else begin
            done       = 1'b0;
            state_next = S_POP_WAIT;
          end
        end
      end
      S_PUSH_WAIT: begin
        state_next = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        mem_req.val_we     = 1'b1;
        mem_req.link_we    = 1'b1;
        mem_req.link_wdata = (cnt_zero || list_is_queue[id]) ? '0 : head_ptr[id];
        if (list_is_queue[id] && !cnt_zero) begin
          state_next = S_PUSH_LINK;
        end else begin
          done       = 1'b1;
          res.status = msqe_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
      S_PUSH_LINK: begin
        mem_req.link_we    = 1'b1;
        mem_req.waddr      = tail_ptr[id];
        mem_req.link_wdata = node;
        done               = 1'b1;
        res.status         = msqe_pkg::ST_OK;
        state_next         = S_IDLE;
      end
      S_POP_WAIT: begin
        mem_req.link_we    = 1'b1;
        mem_req.waddr      = head_ptr[id];
        mem_req.link_wdata = free_head;
        done               = 1'b1;
        res.status         = msqe_pkg::ST_OK;
        res.popped_value   = 32'(val_rdata);
        res.value_valid    = 1'b1;
        state_next         = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Command latch, node pointer and per-list pointers (no reset needed).
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd <= cmd_in;
    end
    case (state)
      S_DECODE: begin
        node <= fresh_ptr[msqe_pkg::PTR_W-1:0];
      end
      S_PUSH_WAIT: begin
        node <= free_head;
      end
      S_PUSH_WR: begin
        if (cnt_zero) begin
          head_ptr[id] <= node;
          tail_ptr[id] <= node;
        end else if (!list_is_queue[id]) begin
          head_ptr[id] <= node;
        end
      end
      S_PUSH_LINK: begin
        tail_ptr[id] <= node;
      end
      S_POP_WAIT: begin
        if (entry_count[id] > msqe_pkg::CNT_W'(1)) begin
          head_ptr[id] <= link_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: sequencer, list flags, counts and free-list bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fresh_ptr  <= '0;
      free_head  <= '0;
      free_count <= '0;
      for (int i = 0; i < msqe_pkg::NUM_LISTS; i++) begin
        list_exists[i]   <= 1'b0;
        list_is_queue[i] <= 1'b0;
        entry_count[i]   <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_DECODE: begin
          if (id_ok && cmd.mode == msqe_pkg::MODE_CREATE && !list_exists[id]) begin
            list_exists[id]   <= 1'b1;
            list_is_queue[id] <= cmd.kind;
            entry_count[id]   <= '0;
          end
          if (state_next == S_PUSH_WR) begin
            fresh_ptr <= fresh_ptr + 1'b1;
          end
        end
        S_PUSH_WAIT: begin
          free_head  <= link_rdata;
          free_count <= free_count - 1'b1;
        end
        S_PUSH_WR: begin
          entry_count[id] <= entry_count[id] + 1'b1;
        end
        S_POP_WAIT: begin
          entry_count[id] <= entry_count[id] - 1'b1;
          free_head       <= head_ptr[id];
          free_count      <= free_count + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/multi_stack_queue_engine_unit.sv
// Linked-list container manager: up to 16 numbered stacks or queues share a
// pool of 1024 nodes held in two single-port-write, registered-read memories
// (node value and node link). Issue a request by raising start while busy is
// low; the request is taken at that edge and busy stays high until the
// sequencer finishes. Every request returns exactly one result, shown on
// result for a single cycle with done high; the receiver cannot stall it, so
// capture it when done is seen. Create, the unused mode and every error
// finish after decoding alone; pop takes one memory read of the head node,
// then the link write that returns it to the free list; push writes a
// never-used node directly, but first reads the free-list link when it
// recycles a node from the free list, plus a step for a non-empty queue
// to link the old tail. Busy falls at the same edge at which done rises,
// so the next request can already be taken in the cycle that shows the
// result. The registered memory read port and the link write port set
// these steps. Nodes read before they are written hold no defined value;
// no legal request sequence exposes that.
module multi_stack_queue_engine_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  msqe_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done,
  output msqe_pkg::res_t result
);

  msqe_pkg::mem_req_t               mem_req;
  logic [msqe_pkg::VALUE_WIDTH-1:0] val_rdata;
  logic [msqe_pkg::PTR_W-1:0]       link_rdata;
  logic                             seq_done;
  msqe_pkg::res_t                   seq_res;

  msqe_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd_in     (cmd),
    .val_rdata  (val_rdata),
    .link_rdata (link_rdata),
    .mem_req    (mem_req),
    .busy       (busy),
    .done       (seq_done),
    .res        (seq_res)
  );

  // Node payload words.
  msqe_ram #(
    .WIDTH (msqe_pkg::VALUE_WIDTH),
    .DEPTH (msqe_pkg::POOL_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (mem_req.val_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.val_wdata),
    .raddr (mem_req.raddr),
    .rdata (val_rdata)
  );

  // Node links: next node in a container, or next node on the free list.
  msqe_ram #(
    .WIDTH (msqe_pkg::PTR_W),
    .DEPTH (msqe_pkg::POOL_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_req.link_we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.link_wdata),
    .raddr (mem_req.raddr),
    .rdata (link_rdata)
  );

  // Register the result: hold it for one cycle with done as its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= seq_done;
    end
    result <= seq_res;
  end

  // A taken request must keep the sequencer busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer not busy");

  // A result only follows a cycle in which the sequencer was working.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  // A popped word only comes with a good status.
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.value_valid) |-> (result.status == msqe_pkg::ST_OK))
    else $error("popped value marked valid on an error status");

  // Results without a valid mark, every error among them, carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.value_valid) |-> (result.popped_value == '0))
    else $error("nonzero popped value without a valid mark");

endmodule

### test/msqe_container_checker.sv
`timescale 1ns / 100ps

module msqe_container_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  msqe_pkg::cmd_t cmd,
  input  logic           done,
  input  msqe_pkg::res_t result,
  output int             error_count,
  output int             outstanding
);

  // Shadow copy of the container bookkeeping and the shared node pool.
  logic                             live      [msqe_pkg::NUM_LISTS];
  logic                             fifo      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::PTR_W-1:0]       head      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::PTR_W-1:0]       tail      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::CNT_W-1:0]       fill      [msqe_pkg::NUM_LISTS];
  logic [msqe_pkg::VALUE_WIDTH-1:0] node_word [msqe_pkg::POOL_DEPTH];
  logic [msqe_pkg::PTR_W-1:0]       node_next [msqe_pkg::POOL_DEPTH];
  logic [msqe_pkg::CNT_W-1:0]       fresh_idx;
  logic [msqe_pkg::CNT_W-1:0]       free_cnt;
  logic [msqe_pkg::PTR_W-1:0]       free_top;

  msqe_pkg::res_t awaited_results [$];

  function automatic msqe_pkg::res_t apply_command(msqe_pkg::cmd_t c);
    msqe_pkg::res_t             r;
    int                         id;
    logic [msqe_pkg::PTR_W-1:0] n;
    logic                       got;
    r      = '0;
    got    = 1'b0;
    id     = int'(c.list_id);
    r.status = msqe_pkg::ST_OK;
    if (c.mode == msqe_pkg::MODE_NONE) begin
      r.status = msqe_pkg::ST_OK;
    end else if (id >= msqe_pkg::NUM_LISTS) begin
      r.status = msqe_pkg::ST_MISSING;
    end else if (c.mode == msqe_pkg::MODE_CREATE) begin
      if (live[id]) begin
        r.status = msqe_pkg::ST_EXISTS;
      end else begin
        live[id] = 1'b1;
        fifo[id] = c.kind;
        fill[id] = '0;
      end
    end else if (!live[id]) begin
      r.status = msqe_pkg::ST_MISSING;
    end else if (c.mode == msqe_pkg::MODE_PUSH) begin
      // recycled nodes first, then the never-used part of the pool
      if (free_cnt != 0) begin
        n        = free_top;
        free_top = node_next[n];
        free_cnt = free_cnt - 1'b1;
        got      = 1'b1;
      end else if (fresh_idx < msqe_pkg::POOL_DEPTH) begin
        n         = fresh_idx[msqe_pkg::PTR_W-1:0];
        fresh_idx = fresh_idx + 1'b1;
        got       = 1'b1;
      end
      if (!got) begin
        r.status = msqe_pkg::ST_FULL;
      end else begin
        node_word[n] = c.value[msqe_pkg::VALUE_WIDTH-1:0];
        if (fill[id] == 0) begin
          node_next[n] = '0;
          head[id]     = n;
          tail[id]     = n;
        end else if (fifo[id]) begin
          node_next[tail[id]] = n;
          node_next[n]        = '0;
          tail[id]            = n;
        end else begin
          node_next[n] = head[id];
          head[id]     = n;
        end
        fill[id] = fill[id] + 1'b1;
      end
    end else if (fill[id] == 0) begin
      r.status = msqe_pkg::ST_EMPTY;
    end else begin
      n              = head[id];
      r.popped_value = node_word[n];
      r.value_valid  = 1'b1;
      if (fill[id] > 1) head[id] = node_next[n];
      fill[id]     = fill[id] - 1'b1;
      node_next[n] = free_top;
      free_top     = n;
      free_cnt     = free_cnt + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    msqe_pkg::res_t want;
    if (rst) begin
      for (int i = 0; i < msqe_pkg::NUM_LISTS; i++) begin
        live[i] = 1'b0;
        fifo[i] = 1'b0;
        fill[i] = '0;
      end
      fresh_idx = '0;
      free_cnt  = '0;
      free_top  = '0;
      awaited_results.delete();
      error_count = 0;
      outstanding = 0;
    end else begin
      // the result of an older request is checked before a new one is queued
      if (done) begin
        if (awaited_results.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result with none pending: status %0d value %0d valid %0b",
                     $realtime, result.status, result.popped_value, result.value_valid);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.popped_value !== want.popped_value ||
              result.value_valid !== want.value_valid) begin
            if (error_count < 10)
              $display("%0t: mismatch: status %0d/%0d value %0d/%0d valid %0b/%0b (exp/act)",
                       $realtime, want.status, result.status, want.popped_value,
                       result.popped_value, want.value_valid, result.value_valid);
            error_count++;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(apply_command(cmd));
      outstanding = awaited_results.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  logic           done;
  msqe_pkg::cmd_t cmd;
  msqe_pkg::res_t result;
  int             error_count;
  int             outstanding;

  // Lists this side has asked to create; steers most requests toward them.
  logic made [msqe_pkg::NUM_LISTS];
  // Requests left in the current back-to-back stretch.
  int   burst_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  multi_stack_queue_engine_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Predict and compare every result beside the block.
  msqe_container_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  function automatic msqe_pkg::cmd_t make_cmd(logic [1:0] mode, int id, logic kind,
                                              logic [31:0] value);
    msqe_pkg::cmd_t c;
    c.mode    = mode;
    c.list_id = id[3:0];
    c.kind    = kind;
    c.value   = value;
    return c;
  endfunction

  // Mostly random words, with the sign and magnitude extremes mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Pick a list id: mostly one already created, sometimes any id at all.
  function automatic int pick_list();
    int id;
    id = $urandom_range(0, msqe_pkg::NUM_LISTS - 1);
    if ($urandom_range(0, 99) < 85)
      for (int k = 0; k < msqe_pkg::NUM_LISTS && !made[id]; k++)
        id = (id + 1) % msqe_pkg::NUM_LISTS;
    return id;
  endfunction

  // Build one random request; the unused mode takes whatever share is left.
  function automatic msqe_pkg::cmd_t random_cmd(int push_pct, int pop_pct, int create_pct);
    int         r;
    logic [1:0] mode;
    int         id;
    r  = $urandom_range(0, 99);
    id = pick_list();
    if (r < push_pct) begin
      mode = msqe_pkg::MODE_PUSH;
    end else if (r < push_pct + pop_pct) begin
      mode = msqe_pkg::MODE_POP;
    end else if (r < push_pct + pop_pct + create_pct) begin
      mode = msqe_pkg::MODE_CREATE;
      id   = $urandom_range(0, msqe_pkg::NUM_LISTS - 1);
    end else begin
      mode = msqe_pkg::MODE_NONE;
      id   = $urandom_range(0, msqe_pkg::NUM_LISTS - 1);
    end
    // kind and value ride along on every request, even where they are ignored
    return make_cmd(mode, id, 1'($urandom_range(0, 1)), pick_word());
  endfunction

  // Drive one request at the falling edge, hold it until busy is low at a
  // rising edge, then idle for a random gap. Keep start high across requests
  // with no gap so back-to-back issue is exercised.
  task automatic issue_request(msqe_pkg::cmd_t c);
    int n;
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    // busy only moves at rising edges, so its value now decides the next edge
    while (busy) @(negedge clk);
    @(posedge clk);
    if (c.mode == msqe_pkg::MODE_CREATE) made[c.list_id] = 1'b1;

    if (burst_left > 0) begin
      burst_left--;
      n = 0;
    end else begin
      case ($urandom_range(0, 19))
        0:                    begin burst_left = $urandom_range(10, 40); n = 0; end
        1, 2:                 n = $urandom_range(8, 30);
        3, 4, 5, 6, 7, 8, 9:  n = $urandom_range(1, 3);
        default:              n = 0;
      endcase
    end
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= make_cmd(2'($urandom_range(0, 3)), int'($urandom_range(0, 15)),
                        1'($urandom_range(0, 1)), $urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every pending request has returned its
  // result, then let the sequencer settle.
  task automatic wait_all_results();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    burst_left = 0;
    for (int i = 0; i < msqe_pkg::NUM_LISTS; i++) made[i] = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, issued back to back.
    burst_left = 40;
    // pop and push on lists that do not exist yet
    issue_request(make_cmd(msqe_pkg::MODE_POP, 0, 1'b0, 32'h0));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 15, 1'b1, 32'hFFFF_FFFF));
    // one stack, one queue, then a create on an id already in use
    issue_request(make_cmd(msqe_pkg::MODE_CREATE, 0, 1'b0, 32'h1234_5678));
    issue_request(make_cmd(msqe_pkg::MODE_CREATE, 1, 1'b1, 32'h0));
    issue_request(make_cmd(msqe_pkg::MODE_CREATE, 0, 1'b1, 32'h0));
    // pops on empty containers
    issue_request(make_cmd(msqe_pkg::MODE_POP, 0, 1'b0, 32'h0));
    issue_request(make_cmd(msqe_pkg::MODE_POP, 1, 1'b1, 32'h0));
    // extreme words into the stack and the queue
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 0, 1'b0, 32'h7FFF_FFFF));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 0, 1'b1, 32'h8000_0000));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 0, 1'b0, 32'h0000_0000));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 0, 1'b1, 32'hFFFF_FFFF));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 1, 1'b0, 32'h8000_0000));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 1, 1'b1, 32'h7FFF_FFFF));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 1, 1'b0, 32'hFFFF_FFFF));
    // unused mode with every other field set
    issue_request(make_cmd(msqe_pkg::MODE_NONE, 15, 1'b1, 32'hFFFF_FFFF));
    // stack comes back reversed and then runs empty; queue comes back in order
    repeat (5) issue_request(make_cmd(msqe_pkg::MODE_POP, 0, 1'b0, 32'h0));
    repeat (3) issue_request(make_cmd(msqe_pkg::MODE_POP, 1, 1'b1, 32'hFFFF_FFFF));
    issue_request(make_cmd(msqe_pkg::MODE_CREATE, 15, 1'b1, 32'h0));
    issue_request(make_cmd(msqe_pkg::MODE_PUSH, 15, 1'b0, 32'hA5A5_A5A5));
    burst_left = 0;

    // Pause the sender until the block has answered everything.
    wait_all_results();

    // Mixed traffic: lists appear over time, nodes get recycled.
    repeat (150) issue_request(random_cmd(45, 35, 15));

    // Push-heavy traffic to grow deep lists, with a few pops so freed
    // nodes are handed out again.
    repeat (300) issue_request(random_cmd(94, 6, 0));
    wait_all_results();

    // Pop-heavy traffic: drain lists, run some empty, reuse the free list.
    repeat (125) issue_request(random_cmd(35, 50, 10));
    wait_all_results();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/msqe_pkg.sv
sv/msqe_ram.sv
sv/msqe_seq.sv
sv/multi_stack_queue_engine_unit.sv
test/msqe_container_checker.sv
test/tb.sv
